/* rtl/core/keypoint_grid_bucket_filter_defines.svh */
// Assertion macros for the keypoint grid bucket filter RTL.
// Included by keypoint_grid_bucket_filter.sv; expects clk and rst in scope.
`ifndef KEYPOINT_GRID_BUCKET_FILTER_DEFINES_SVH
`define KEYPOINT_GRID_BUCKET_FILTER_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define KGBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset
`define KGBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/kgbf_pkg.sv */
// Shared types and constants for the keypoint grid bucket filter.
// No dependencies; imported by every module of the block.
package kgbf_pkg;

  localparam int COORD_W     = 12;
  localparam int POINT_W     = 16;
  localparam int TAG_W       = 10;
  localparam int CELL_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;

  localparam int GRID_COLS_DEFAULT = 16;
  localparam int GRID_ROWS_DEFAULT = 16;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd480;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Result status codes
  localparam logic [1:0] ST_KEPT      = 2'd0;
  localparam logic [1:0] ST_OUT_IMAGE = 2'd1;
  localparam logic [1:0] ST_OUT_GRID  = 2'd2;
  localparam logic [1:0] ST_TAKEN     = 2'd3;

  typedef struct packed {
    logic                      first_in_set;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [TAG_W-1:0]          match_tag;
  } point_t;

  typedef struct packed {
    logic              keep;
    logic [TAG_W-1:0]  tag_out;
    logic [1:0]        status;
    logic [CELL_W-1:0] cell_index;
  } result_t;

  // Occupancy map control from the sequencer
  typedef struct packed {
    logic clear;
    logic rd_en;
    logic commit;
  } occ_ctl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/core/keypoint_grid_bucket_filter.sv */
// Keypoint grid bucket filter: keeps the first keypoint in each grid cell.
// Usage:
//   point channel (point_valid/point_stall/point) takes one keypoint word;
//   result channel (result_valid/result_stall/result) gives one word per point.
//   cfg_we/cfg_index/cfg_data write image_width (0) or image_height (1); the
//   cell steps are recomputed at the write. Write only while the block is idle.
// Sequence:
//   A point inside the grid is judged by two restoring dividers that produce
//   one quotient bit per cycle, QB = clog2(max(GRID_COLS, GRID_ROWS)) bits,
//   then one occupancy memory read and, for a kept point, one write back.
//   Its result is loaded into the output register from S_LOOKUP, after
//   S_CHECK, S_DIV and S_READ; a new point is taken only back in S_IDLE.
//   A point outside the image or grid has its result loaded from S_CHECK,
//   and the next point is taken once the block is back in S_IDLE.
// Reset clears the occupancy map and loads 640 x 480. A result waits in the
// output register while result_stall is high; the next point may be accepted
// meanwhile but is held before the output until the register frees up.
`include "keypoint_grid_bucket_filter_defines.svh"

module keypoint_grid_bucket_filter
  import kgbf_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEFAULT,
  parameter int GRID_ROWS = GRID_ROWS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  point_t                point,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int QB     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int LIM_W  = COORD_W + 7;
  localparam int NUM_W  = ($clog2(GRID_COLS * GRID_ROWS) > CELL_W) ?
                          $clog2(GRID_COLS * GRID_ROWS) : CELL_W;

  // Reciprocals for the cell steps, exact for 12-bit sizes and up to 64 cells
  localparam int RCP_SH = COORD_W + 6;
  localparam int RCP_W  = RCP_SH + 1;
  localparam int PROD_W = COORD_W + RCP_W;
  localparam logic [RCP_W-1:0] COL_RCP =
    RCP_W'(((1 << RCP_SH) + GRID_COLS - 1) / GRID_COLS);
  localparam logic [RCP_W-1:0] ROW_RCP =
    RCP_W'(((1 << RCP_SH) + GRID_ROWS - 1) / GRID_ROWS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_LOOKUP = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [COORD_W-1:0]  image_width;
  logic [COORD_W-1:0]  image_height;
  logic [COORD_W-1:0]  column_step;
  logic [COORD_W-1:0]  row_step;
  logic [PROD_W-1:0]   col_prod;
  logic [PROD_W-1:0]   row_prod;
  logic [POINT_W-1:0]  x_q;
  logic [POINT_W-1:0]  y_q;
  logic [TAG_W-1:0]    tag_q;
  logic                accept;
  logic                out_free;
  logic                load;
  logic                div_start;
  logic                out_image;
  logic                out_grid;
  logic [LIM_W-1:0]    col_limit;
  logic [LIM_W-1:0]    row_limit;
  logic [QB-1:0]       quo_x;
  logic [QB-1:0]       quo_y;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [NUM_W-1:0]    cell_num;
  logic                taken;
  occ_ctl_t            occ_ctl;
  div_stat_t           col_stat;
  div_stat_t           row_stat;
  result_t             result_next;

  assign point_stall = (state != S_IDLE);
  assign accept      = point_valid && !point_stall;
  assign out_free    = !result_valid || !result_stall;

  // Divide the written size by the grid count with a reciprocal multiply
  assign col_prod = PROD_W'(cfg_data) * PROD_W'(COL_RCP);
  assign row_prod = PROD_W'(cfg_data) * PROD_W'(ROW_RCP);

  // Configuration registers and derived cell steps
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      column_step  <= COORD_W'(WIDTH_RESET / GRID_COLS);
      row_step     <= COORD_W'(HEIGHT_RESET / GRID_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data;
          column_step <= col_prod[RCP_SH +: COORD_W];
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          row_step     <= row_prod[RCP_SH +: COORD_W];
        end
        default: begin
        end
      endcase
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q   <= point.point_x;
      y_q   <= point.point_y;
      tag_q <= point.match_tag;
    end
  end

  // Bounds: a negative coordinate compares as a large unsigned value
  assign out_image = (x_q >= POINT_W'(image_width)) || (y_q >= POINT_W'(image_height));
  assign col_limit = LIM_W'(column_step) * LIM_W'(GRID_COLS);
  assign row_limit = LIM_W'(row_step) * LIM_W'(GRID_ROWS);
  assign out_grid  = (column_step == '0) || (row_step == '0) ||
                     (LIM_W'(x_q[COORD_W-1:0]) >= col_limit) ||
                     (LIM_W'(y_q[COORD_W-1:0]) >= row_limit);

  assign col      = quo_x[COL_W-1:0];
  assign row      = quo_y[ROW_W-1:0];
  assign cell_num = NUM_W'(row) * NUM_W'(GRID_COLS) + NUM_W'(col);

  // Sequencer: next state, divider start, memory control, result word
  always_comb begin
    state_next      = state;
    div_start       = 1'b0;
    load            = 1'b0;
    occ_ctl.clear   = 1'b0;
    occ_ctl.rd_en   = 1'b0;
    occ_ctl.commit  = 1'b0;
    result_next.keep       = 1'b0;
    result_next.tag_out    = tag_q;
    result_next.status     = ST_OUT_IMAGE;
    result_next.cell_index = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          occ_ctl.clear = point.first_in_set;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_image || out_grid) begin
          result_next.status = out_image ? ST_OUT_IMAGE : ST_OUT_GRID;
          if (out_free) begin
            load       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (col_stat.done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        occ_ctl.rd_en = 1'b1;
        state_next    = S_LOOKUP;
      end
      S_LOOKUP: begin
        result_next.cell_index = cell_num[CELL_W-1:0];
        result_next.status     = taken ? ST_TAKEN : ST_KEPT;
        result_next.keep       = !taken;
        if (out_free) begin
          load           = 1'b1;
          occ_ctl.commit = !taken;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  kgbf_div #(
    .QUO_W (QB)
  ) u_div_col (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x_q[COORD_W-1:0]),
    .divisor  (column_step),
    .stat     (col_stat),
    .quotient (quo_x)
  );

  kgbf_div #(
    .QUO_W (QB)
  ) u_div_row (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (y_q[COORD_W-1:0]),
    .divisor  (row_step),
    .stat     (row_stat),
    .quotient (quo_y)
  );

  kgbf_occ #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .COL_W     (COL_W),
    .ROW_W     (ROW_W)
  ) u_occ (
    .clk   (clk),
    .rst   (rst),
    .ctl   (occ_ctl),
    .row   (row),
    .col   (col),
    .taken (taken)
  );

  // Checks
  `KGBF_ASSERT_NEXT(a_accept_to_check, accept, state == S_CHECK, "accepted word not checked")
  `KGBF_ASSERT_NEXT(a_commit_keeps, occ_ctl.commit, result_valid && result.keep, "commit, no keep")
  `KGBF_ASSERT_NOW(a_keep_status, result_valid, result.keep == (result.status == ST_KEPT), "keep flag and status disagree")
  `KGBF_ASSERT_NOW(a_div_active, state == S_DIV, col_stat.busy || col_stat.done, "waiting on an idle divider")
  `KGBF_ASSERT_NOW(a_div_lockstep, 1'b1, col_stat == row_stat, "dividers out of step")

endmodule

/* rtl/core/kgbf_div.sv */
// Restoring divider, one quotient bit per cycle, for grid column/row lookup.
// Depends on kgbf_pkg; the caller guarantees the quotient fits QUO_W bits.
module kgbf_div
  import kgbf_pkg::*;
#(
  parameter int QUO_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [COORD_W-1:0] divisor,
  output div_stat_t          stat,
  output logic [QUO_W-1:0]   quotient
);

  localparam int DSR_W = COORD_W + QUO_W - 1;
  localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [COORD_W-1:0] rem;
  logic [DSR_W-1:0]   dsr;
  logic [CNT_W-1:0]   count;
  logic               busy;
  logic               done;
  logic               ge;

  // Trial subtract against the shifted divisor
  assign ge = DSR_W'(rem) >= dsr;

  // Control: count QUO_W iterations, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 1'b1;
      end
    end
  end

  // Datapath: remainder, divisor and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= DSR_W'(divisor) << (QUO_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsr[COORD_W-1:0];
      end
      quotient <= QUO_W'({quotient, ge});
      dsr      <= dsr >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/core/kgbf_occ.sv */
// Occupancy map: one row of cell bits per memory word, with per-row valid flops.
// Depends on kgbf_pkg; registered read, read-modify-write on commit.
module kgbf_occ
  import kgbf_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEFAULT,
  parameter int GRID_ROWS = GRID_ROWS_DEFAULT,
  parameter int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1,
  parameter int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  occ_ctl_t         ctl,
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] col,
  output logic             taken
);

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_valid;
  logic [GRID_COLS-1:0] rd_word;
  logic                 rd_valid;
  logic [ROW_W-1:0]     row_q;
  logic [GRID_COLS-1:0] word_now;

  // A row not written since the last clear reads as empty
  assign word_now = rd_valid ? rd_word : '0;
  assign taken    = word_now[col];

  // Memory: registered read, write back the row with the cell set
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_word  <= mem[row];
      rd_valid <= row_valid[row];
      row_q    <= row;
    end
    if (ctl.commit) begin
      mem[row_q] <= word_now | (GRID_COLS'(1) << col);
    end
  end

  // Row valid flags: drop all on a new set, mark a row once written
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ctl.clear) begin
      row_valid <= '0;
    end else if (ctl.commit) begin
      row_valid[row_q] <= 1'b1;
    end
  end

endmodule
